// File: design/itaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package itaf_pkg;

  typedef enum logic [1:0] {
    MODE_UDEC = 2'd0,
    MODE_SDEC = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_BIN  = 2'd3
  } mode_e;

  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned NUM_STG    = NUM_DIGITS + 1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ALPHA = 8'h37;  // 'A' - 10

  // Decimal place weights, most significant first
  localparam logic [33:0] POW10 [NUM_DIGITS] = '{
    34'd1000000000, 34'd100000000, 34'd10000000, 34'd1000000, 34'd100000,
    34'd10000, 34'd1000, 34'd100, 34'd10, 34'd1
  };

  typedef struct packed {
    logic [31:0] mag;
    logic [39:0] dig;
    mode_e       mode;
    logic        line_end;
    logic        neg;
  } stg_t;

  function automatic logic [7:0] nib_char(input logic [3:0] nib);
    if (nib <= 4'd9) begin
      nib_char = CH_ZERO + {4'd0, nib};
    end else begin
      nib_char = CH_ALPHA + {4'd0, nib};
    end
  endfunction

endpackage
`default_nettype wire

// File: design/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Signals                          Transaction
// command   in         start_i, busy_o, value_i,        start_i high, busy_o low
//                      mode_i, line_end_i
// result    out        out_strobe_o, ascii_char_o,      every cycle out_strobe_o is high
//                      last_o
//
// An item runs through an eleven-stage digit pipeline (input stage, then one
// decimal digit per stage); with nothing ahead of it, it passes every stage in
// turn, loads into the serialiser and has its first character on the result
// ports in the cycle after the load. The serialiser sends one character per
// cycle: 10 per decimal item (11 with a minus), 8 in hex, 32 in binary, plus
// CR and LF with line end, back to back; busy_o rises once the backlog reaches
// the input stage. Reset clears all stage valid bits and idles the serialiser.
module integer_to_ascii_formatter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] value_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic        line_end_i,
  output logic             out_strobe_o,
  output logic [7:0]       ascii_char_o,
  output logic             last_o
);
  import itaf_pkg::*;

  typedef enum logic [1:0] {
    SER_IDLE,
    SER_DIGIT,
    SER_CR,
    SER_LF
  } ser_state_e;

  // ---------------------------------------------------------------- pipeline
  stg_t stg_q   [NUM_STG];
  logic vld_q   [NUM_STG];
  logic adv     [NUM_STG];
  logic ser_free;
  logic accept;
  stg_t in_stg;

  // A stage moves on when the next one is empty or moving on too
  assign adv[NUM_STG-1] = vld_q[NUM_STG-1] & ser_free;
  for (genvar g = 0; g < NUM_STG - 1; g++) begin : g_adv
    assign adv[g] = vld_q[g] & (~vld_q[g+1] | adv[g+1]);
  end

  assign busy_o = vld_q[0] & ~adv[0];
  assign accept = start_i & ~busy_o;

  always_comb begin
    in_stg          = '0;
    in_stg.mode     = mode_e'(mode_i);
    in_stg.line_end = line_end_i;
    in_stg.neg      = (mode_e'(mode_i) == MODE_SDEC) & value_i[31];
    in_stg.mag      = in_stg.neg ? (32'd0 - value_i) : value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (accept) begin
      vld_q[0] <= 1'b1;
    end else if (adv[0]) begin
      vld_q[0] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q[0] <= in_stg;
    end
  end

  for (genvar s = 1; s < NUM_STG; s++) begin : g_stg
    stg_t nxt;
    logic [3:0]  digit;
    logic [33:0] sub;
    logic        dec;

    // In decimal modes, pick the largest multiple of this place weight that fits
    always_comb begin
      dec   = (stg_q[s-1].mode == MODE_UDEC) | (stg_q[s-1].mode == MODE_SDEC);
      digit = 4'd0;
      sub   = '0;
      for (int m = 1; m <= 9; m++) begin
        if (dec && ({2'b00, stg_q[s-1].mag} >= 34'(m) * POW10[s-1])) begin
          digit = 4'(m);
          sub   = 34'(m) * POW10[s-1];
        end
      end
      nxt     = stg_q[s-1];
      nxt.mag = stg_q[s-1].mag - sub[31:0];
      nxt.dig = {stg_q[s-1].dig[35:0], digit};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv[s-1]) begin
        vld_q[s] <= 1'b1;
      end else if (adv[s]) begin
        vld_q[s] <= 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s-1]) begin
        stg_q[s] <= nxt;
      end
    end
  end

  // -------------------------------------------------------------- serialiser
  ser_state_e  state_q;
  logic [39:0] sh_q;
  logic [4:0]  cnt_q;
  mode_e       mode_q;
  logic        le_q;
  logic        neg_q;
  logic        lead_q;
  logic        sign_q;
  logic        strobe_q;
  logic [7:0]  char_q;
  logic        last_q;

  logic [3:0]  d;
  logic        nz;
  logic        put_minus;
  logic        fin_dig;
  logic [7:0]  dchar;
  logic [39:0] sh_next;
  logic        load;
  stg_t        top;
  logic        top_dec;
  logic [4:0]  top_cnt;

  always_comb begin
    d       = (mode_q == MODE_BIN) ? {3'b000, sh_q[39]} : sh_q[39:36];
    sh_next = (mode_q == MODE_BIN) ? {sh_q[38:0], 1'b0} : {sh_q[35:0], 4'h0};
    nz      = (d != 4'd0);
    put_minus = neg_q & lead_q & nz & ~sign_q;
    if (put_minus) begin
      dchar = CH_MINUS;
    end else if (nz) begin
      dchar = nib_char(d);
    end else if (lead_q && cnt_q != 5'd0) begin
      dchar = CH_SPACE;
    end else begin
      dchar = CH_ZERO;
    end
    fin_dig  = ~put_minus & (cnt_q == 5'd0) & ~le_q;
    ser_free = (state_q == SER_IDLE) | (state_q == SER_LF) |
               ((state_q == SER_DIGIT) & fin_dig);
  end

  assign load    = adv[NUM_STG-1];
  assign top     = stg_q[NUM_STG-1];
  assign top_dec = (top.mode == MODE_UDEC) | (top.mode == MODE_SDEC);

  always_comb begin
    unique case (top.mode)
      MODE_HEX: top_cnt = 5'd7;
      MODE_BIN: top_cnt = 5'd31;
      default:  top_cnt = 5'd9;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SER_IDLE;
      sh_q     <= '0;
      cnt_q    <= '0;
      mode_q   <= MODE_UDEC;
      le_q     <= 1'b0;
      neg_q    <= 1'b0;
      lead_q   <= 1'b0;
      sign_q   <= 1'b0;
      strobe_q <= 1'b0;
      char_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      unique case (state_q)
        SER_IDLE: begin
        end
        SER_DIGIT: begin
          strobe_q <= 1'b1;
          char_q   <= dchar;
          last_q   <= fin_dig;
          if (put_minus) begin
            // hold the digit for the next cycle
            sign_q <= 1'b1;
          end else begin
            sh_q  <= sh_next;
            cnt_q <= cnt_q - 5'd1;
            if (nz) begin
              lead_q <= 1'b0;
            end
            if (cnt_q == 5'd0) begin
              state_q <= le_q ? SER_CR : SER_IDLE;
            end
          end
        end
        SER_CR: begin
          strobe_q <= 1'b1;
          char_q   <= CH_CR;
          state_q  <= SER_LF;
        end
        SER_LF: begin
          strobe_q <= 1'b1;
          char_q   <= CH_LF;
          last_q   <= 1'b1;
          state_q  <= SER_IDLE;
        end
        default: state_q <= SER_IDLE;
      endcase
      if (load) begin
        state_q <= SER_DIGIT;
        sh_q    <= top_dec ? top.dig : {top.mag, 8'h00};
        cnt_q   <= top_cnt;
        mode_q  <= top.mode;
        le_q    <= top.line_end;
        neg_q   <= top.neg;
        lead_q  <= 1'b1;
        sign_q  <= 1'b0;
      end
    end
  end

  assign out_strobe_o = strobe_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

  // -------------------------------------------------------------- assertions
  a_busy_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> !busy_o)
    else $error("busy raised with an empty input stage");

  a_active_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SER_IDLE) |=> out_strobe_o)
    else $error("serialiser active without emitting a character");

  a_minus_signed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && ascii_char_o == CH_MINUS) |-> (neg_q && mode_q == MODE_SDEC))
    else $error("minus sign emitted for a non-negative item");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NUM_STG-1] && !adv[NUM_STG-1]) |=>
      (vld_q[NUM_STG-1] && $stable(stg_q[NUM_STG-1])))
    else $error("last pipeline stage lost or changed a stalled item");

endmodule
`default_nettype wire

// File: tb/tb_integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
module tb_integer_to_ascii_formatter;
  import itaf_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 50;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] value;
  mode_e       mode;
  logic        line_end;
  logic        out_strobe;
  logic [7:0]  ascii_char;
  logic        last_char;

  text_char_t  pending_text[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  integer_to_ascii_formatter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .value_i     (value),
    .mode_i      (mode),
    .line_end_i  (line_end),
    .out_strobe_o(out_strobe),
    .ascii_char_o(ascii_char),
    .last_o      (last_char)
  );

  always #1 clk = ~clk;

  // Work out the characters one number should produce and queue them in order.
  function automatic void format_number(input logic [31:0] num, input mode_e fmt,
                                        input logic crlf);
    logic [7:0]  text[$];
    logic [31:0] mag;
    logic [31:0] weight;
    logic [31:0] digit;
    logic [3:0]  nib;
    logic        neg;
    logic        leading;
    text_char_t  entry;
    text = {};
    leading = 1'b1;
    case (fmt)
      MODE_UDEC, MODE_SDEC: begin
        neg = (fmt == MODE_SDEC) && num[31];
        mag = neg ? (32'd0 - num) : num;
        weight = 32'd1000000000;
        while (weight != 32'd0) begin
          digit = mag / weight;
          if (digit != 32'd0) begin
            if (leading && neg) text.push_back(CH_MINUS);
            text.push_back(CH_ZERO + digit[7:0]);
            leading = 1'b0;
          end else begin
            text.push_back((leading && weight > 32'd1) ? CH_SPACE : CH_ZERO);
          end
          mag = mag % weight;
          weight = weight / 32'd10;
        end
      end
      MODE_HEX: begin
        for (int sh = 28; sh >= 0; sh -= 4) begin
          nib = num[sh +: 4];
          if (nib != 4'd0) begin
            text.push_back((nib <= 4'd9) ? (8'h30 + {4'd0, nib})
                                         : (8'h41 + {4'd0, nib} - 8'd10));
            leading = 1'b0;
          end else begin
            text.push_back((leading && sh > 0) ? CH_SPACE : CH_ZERO);
          end
        end
      end
      default: begin
        for (int sh = 31; sh >= 0; sh--) begin
          if (num[sh]) begin
            text.push_back(8'h31);
            leading = 1'b0;
          end else begin
            text.push_back((leading && sh > 0) ? CH_SPACE : CH_ZERO);
          end
        end
      end
    endcase
    if (crlf) begin
      text.push_back(CH_CR);
      text.push_back(CH_LF);
    end
    for (int k = 0; k < text.size(); k++) begin
      entry.code = text[k];
      entry.last = (k == text.size() - 1);
      pending_text.push_back(entry);
    end
  endfunction

  // Send one number; start is left high so a burst runs back to back.
  task automatic send_number(input logic [31:0] num, input mode_e fmt, input logic crlf);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start    <= 1'b1;
    value    <= num;
    mode     <= fmt;
    line_end <= crlf;
    do @(posedge clk); while (busy);
    format_number(num, fmt, crlf);
  endtask

  task automatic test_unsigned_decimal();
    send_number(32'd0, MODE_UDEC, 1'b0);
    send_number(32'd1, MODE_UDEC, 1'b1);
    send_number(32'd10, MODE_UDEC, 1'b0);
    send_number(32'd999999999, MODE_UDEC, 1'b0);
    send_number(32'd1000000000, MODE_UDEC, 1'b1);
    send_number(32'hFFFF_FFFF, MODE_UDEC, 1'b0);
  endtask

  task automatic test_signed_decimal();
    send_number(32'd0, MODE_SDEC, 1'b1);
    send_number(32'd7, MODE_SDEC, 1'b0);
    send_number(32'hFFFF_FFFF, MODE_SDEC, 1'b0);
    send_number(32'h8000_0000, MODE_SDEC, 1'b1);
    send_number(32'h7FFF_FFFF, MODE_SDEC, 1'b0);
    send_number(32'hC465_3600, MODE_SDEC, 1'b0);
    send_number(32'hFFFF_FFF6, MODE_SDEC, 1'b1);
  endtask

  task automatic test_hexadecimal();
    send_number(32'd0, MODE_HEX, 1'b0);
    send_number(32'h0000_000F, MODE_HEX, 1'b1);
    send_number(32'h0123_4567, MODE_HEX, 1'b0);
    send_number(32'hFEDC_BA98, MODE_HEX, 1'b0);
    send_number(32'hFFFF_FFFF, MODE_HEX, 1'b1);
  endtask

  task automatic test_binary();
    send_number(32'd0, MODE_BIN, 1'b0);
    send_number(32'd1, MODE_BIN, 1'b1);
    send_number(32'h8000_0000, MODE_BIN, 1'b0);
    send_number(32'hFFFF_FFFF, MODE_BIN, 1'b1);
  endtask

  task automatic test_random_numbers(input int unsigned count);
    logic [31:0] num;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0: num = $urandom();
        1: num = $urandom_range(0, 20);
        2: num = 32'd0 - $urandom_range(1, 1000);
        default: num = $urandom() >> $urandom_range(0, 31);
      endcase
      send_number(num, mode_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Compare each character against the oldest one still owed.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_text.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, ascii_char, last_char);
      end else begin
        if (ascii_char !== pending_text[0].code || last_char !== pending_text[0].last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: character mismatch: expected %h last %b, actual %h last %b",
                     $time, pending_text[0].code, pending_text[0].last, ascii_char,
                     last_char);
        end
        void'(pending_text.pop_front());
      end
    end
  end

  // Give up once neither side has moved a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    value    = '0;
    mode     = MODE_UDEC;
    line_end = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unsigned_decimal();
    test_signed_decimal();
    test_hexadecimal();
    test_binary();
    test_random_numbers(98);

    @(negedge clk);
    start <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
design/itaf_pkg.sv
design/integer_to_ascii_formatter.sv
tb/tb_integer_to_ascii_formatter.sv
